### src/gscc_pkg.sv
// Shared types and constants for the gear shift and clutch control block.
// No dependencies; used by gscc_cfg, the top level and the checker.
package gscc_pkg;

  // Field widths
  localparam int unsigned RpmW    = 15;
  localparam int unsigned DistW   = 16;
  localparam int unsigned PressW  = 10;
  localparam int unsigned ClutchW = 11;
  localparam int unsigned HoldW   = 6;
  localparam int unsigned GearW   = 3;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 16;

  // Register reset values
  localparam logic [RpmW-1:0]    UpRpmRst      = 15'd9000;
  localparam logic [RpmW-1:0]    DownRpm2Rst   = 15'd3600;
  localparam logic [RpmW-1:0]    DownRpm3Rst   = 15'd4800;
  localparam logic [RpmW-1:0]    DownRpm4Rst   = 15'd5500;
  localparam logic [RpmW-1:0]    DownRpm5Rst   = 15'd5900;
  localparam logic [RpmW-1:0]    DownRpm6Rst   = 15'd6500;
  localparam logic [PressW-1:0]  PressRst      = 10'd500;
  localparam logic [DistW-1:0]   LaunchRst     = 16'd10;
  localparam logic [ClutchW-1:0] CeilFirstRst  = 11'd650;

  // Shift holdoff loads and clutch decay steps
  localparam logic [HoldW-1:0]   HoldUp        = 6'd20;
  localparam logic [HoldW-1:0]   HoldDown      = 6'd50;
  localparam logic [ClutchW-1:0] StepFast      = 11'd50;
  localparam logic [ClutchW-1:0] StepFirst     = 11'd25;
  localparam logic [ClutchW-1:0] StepSlow      = 11'd40;

  // Largest clutch level that can ever show: floor(1023 * 1.3)
  localparam logic [ClutchW-1:0] ClutchMax     = 11'd1329;

  // Gear codes
  localparam logic [GearW-1:0]   GearFirst     = 3'd1;
  localparam logic [GearW-1:0]   GearTop       = 3'd6;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_UPSHIFT_RPM   = 4'd0,
    CFG_DOWN_RPM_G2   = 4'd1,
    CFG_DOWN_RPM_G3   = 4'd2,
    CFG_DOWN_RPM_G4   = 4'd3,
    CFG_DOWN_RPM_G5   = 4'd4,
    CFG_DOWN_RPM_G6   = 4'd5,
    CFG_PRESS_LEVEL   = 4'd6,
    CFG_LAUNCH_DIST   = 4'd7
  } cfg_idx_e;

  // Register bank contents handed to the datapath
  typedef struct packed {
    logic [RpmW-1:0]    upshift_rpm;
    logic [RpmW-1:0]    down_rpm_g2;
    logic [RpmW-1:0]    down_rpm_g3;
    logic [RpmW-1:0]    down_rpm_g4;
    logic [RpmW-1:0]    down_rpm_g5;
    logic [RpmW-1:0]    down_rpm_g6;
    logic [PressW-1:0]  press_level;
    logic [DistW-1:0]   launch_distance;
    logic [ClutchW-1:0] ceil_first;    // floor(press_level * 1.3)
  } cfg_t;

endpackage

### src/gscc_cfg.sv
// Configuration register bank of the gear shift and clutch control block.
// Depends on gscc_pkg; also precomputes the first-gear clutch ceiling.
module gscc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gscc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gscc_pkg::CfgDatW-1:0]  cfg_data_i,
  output gscc_pkg::cfg_t                cfg_o
);
  import gscc_pkg::*;

  // floor(x / 10) for x < 4096 as (x * 52429) >> 19
  localparam logic [15:0] RecipTenth = 16'd52429;

  cfg_t              cfg_q, cfg_d;
  logic [PressW-1:0] press_new;
  logic [11:0]       press_x3;
  logic [27:0]       tenth_prod;
  logic [8:0]        press_x3_div10;

  // Ceiling in first gear: P + floor(3P / 10)
  always_comb begin
    press_new      = cfg_data_i[PressW-1:0];
    press_x3       = {1'b0, press_new, 1'b0} + {2'b00, press_new};
    tenth_prod     = press_x3 * RecipTenth;
    press_x3_div10 = tenth_prod[27:19];
  end

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UPSHIFT_RPM: cfg_d.upshift_rpm = cfg_data_i[RpmW-1:0];
        CFG_DOWN_RPM_G2: cfg_d.down_rpm_g2 = cfg_data_i[RpmW-1:0];
        CFG_DOWN_RPM_G3: cfg_d.down_rpm_g3 = cfg_data_i[RpmW-1:0];
        CFG_DOWN_RPM_G4: cfg_d.down_rpm_g4 = cfg_data_i[RpmW-1:0];
        CFG_DOWN_RPM_G5: cfg_d.down_rpm_g5 = cfg_data_i[RpmW-1:0];
        CFG_DOWN_RPM_G6: cfg_d.down_rpm_g6 = cfg_data_i[RpmW-1:0];
        CFG_PRESS_LEVEL: begin
          cfg_d.press_level = press_new;
          cfg_d.ceil_first  = {1'b0, press_new} + {2'b00, press_x3_div10};
        end
        CFG_LAUNCH_DIST: cfg_d.launch_distance = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the register values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upshift_rpm     <= UpRpmRst;
      cfg_q.down_rpm_g2     <= DownRpm2Rst;
      cfg_q.down_rpm_g3     <= DownRpm3Rst;
      cfg_q.down_rpm_g4     <= DownRpm4Rst;
      cfg_q.down_rpm_g5     <= DownRpm5Rst;
      cfg_q.down_rpm_g6     <= DownRpm6Rst;
      cfg_q.press_level     <= PressRst;
      cfg_q.launch_distance <= LaunchRst;
      cfg_q.ceil_first      <= CeilFirstRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

endmodule

### src/gear_shift_and_clutch_control.sv
// Top level of the gear shift and clutch control block.
// Depends on gscc_pkg and gscc_cfg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | gear_now_i, engine_rpm_i, distance_raced_i
//   out     | source    | out_valid_o/out_stall_i | gear_command_o, clutch_out_o
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item passes an input register, one pass of compare-and-update logic, then the
// result register. One item per cycle is accepted while the input is not stalled.
// The holdoff and clutch state is updated as an item moves into the result register,
// so the next item always sees it. Reset clears both and loads the register defaults.
// A stalled result holds the result register; input stalls only while both stages are full.
module gear_shift_and_clutch_control (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [3:0]                   gear_now_i,
  input  logic        [gscc_pkg::RpmW-1:0]    engine_rpm_i,
  input  logic        [gscc_pkg::DistW-1:0]   distance_raced_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [gscc_pkg::GearW-1:0]   gear_command_o,
  output logic        [gscc_pkg::ClutchW-1:0] clutch_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [gscc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic        [gscc_pkg::CfgDatW-1:0] cfg_data_i
);
  import gscc_pkg::*;

  cfg_t cfg;

  gscc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline registers
  logic               s1_valid_q, s1_valid_d;
  logic signed [3:0]  s1_gear_q;
  logic [RpmW-1:0]    s1_rpm_q;
  logic [DistW-1:0]   s1_dist_q;
  logic               out_valid_q, out_valid_d;
  logic [GearW-1:0]   out_gear_q;
  logic [ClutchW-1:0] out_clutch_q;

  // Block state
  logic [HoldW-1:0]   hold_q, hold_d;
  logic [ClutchW-1:0] clutch_q, clutch_d;

  // Handshake
  logic in_fire, out_free, s1_fire;

  // Datapath
  logic               gear_low;
  logic [GearW-1:0]   gear_pos;
  logic [HoldW-1:0]   hold_dec;
  logic [RpmW-1:0]    down_thr;
  logic               up_shift, down_shift, first_rule;
  logic [GearW-1:0]   gear_cmd;
  logic [ClutchW-1:0] press_ext, lvl, ceil_lvl, step;
  logic [HoldW-1:0]   hold_new;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Clamp the gear: negative or neutral counts as low, seven counts as six
  always_comb begin
    gear_low = s1_gear_q[3] || (s1_gear_q == 4'sd0);
    gear_pos = (s1_gear_q[2:0] == 3'd7) ? GearTop : s1_gear_q[2:0];
  end

  // Pick the downshift threshold of the current gear
  always_comb begin
    case (gear_pos)
      3'd2:    down_thr = cfg.down_rpm_g2;
      3'd3:    down_thr = cfg.down_rpm_g3;
      3'd4:    down_thr = cfg.down_rpm_g4;
      3'd5:    down_thr = cfg.down_rpm_g5;
      3'd6:    down_thr = cfg.down_rpm_g6;
      default: down_thr = '0;
    endcase
  end

  // Shift decision
  always_comb begin
    hold_dec   = (hold_q != '0) ? hold_q - 1'b1 : '0;
    up_shift   = !gear_low && (gear_pos < GearTop) &&
                 (s1_rpm_q > cfg.upshift_rpm) && (hold_dec == '0);
    down_shift = !gear_low && !up_shift && (gear_pos > GearFirst) &&
                 (s1_rpm_q < down_thr) && (hold_dec == '0);
    if (gear_low) begin
      gear_cmd = GearFirst;
    end else if (up_shift) begin
      gear_cmd = gear_pos + 1'b1;
    end else if (down_shift) begin
      gear_cmd = gear_pos - 1'b1;
    end else begin
      gear_cmd = gear_pos;
    end
    if (up_shift) begin
      hold_new = HoldUp;
    end else if (down_shift) begin
      hold_new = HoldDown;
    end else begin
      hold_new = hold_dec;
    end
  end

  // Clutch: press on a shift or at launch, clamp to the ceiling, then decay
  always_comb begin
    press_ext  = {1'b0, cfg.press_level};
    first_rule = gear_low || (gear_pos == GearFirst);
    ceil_lvl   = first_rule ? cfg.ceil_first : press_ext;
    step       = first_rule ? StepFirst : StepFast;
    lvl        = (up_shift || down_shift) ? press_ext : clutch_q;
    if (s1_dist_q < cfg.launch_distance) begin
      lvl = press_ext;
    end
    if (lvl != '0) begin
      if (lvl > ceil_lvl) begin
        lvl = ceil_lvl;
      end
      if (lvl != ceil_lvl) begin
        lvl = (lvl > step) ? lvl - step : '0;
      end else begin
        lvl = (lvl > StepSlow) ? lvl - StepSlow : '0;
      end
    end
  end

  // Next-state selection
  always_comb begin
    s1_valid_d  = in_fire || (s1_valid_q && !out_free);
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
    hold_d      = s1_fire ? hold_new : hold_q;
    clutch_d    = s1_fire ? lvl : clutch_q;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hold_q      <= '0;
      clutch_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      hold_q      <= hold_d;
      clutch_q    <= clutch_d;
    end
  end

  // Capture the input item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_gear_q <= gear_now_i;
      s1_rpm_q  <= engine_rpm_i;
      s1_dist_q <= distance_raced_i;
    end
  end

  // Advance the result into the output register
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_gear_q   <= gear_cmd;
      out_clutch_q <= lvl;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gear_command_o = out_gear_q;
  assign clutch_out_o   = out_clutch_q;

endmodule

### src/gscc_checker.sv
// Port-level checker for the gear shift and clutch control block.
// Depends on gscc_pkg; bound to the top level at the end of this file.
module gscc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic        [gscc_pkg::GearW-1:0]   gear_command_o,
  input logic        [gscc_pkg::ClutchW-1:0] clutch_out_o
);
  import gscc_pkg::*;

  // A stalled item holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(gear_command_o) &&
                                    $stable(clutch_out_o))
    else $error("stalled result item changed");

  // Input stalls only when the result side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  // Commanded gear is always a forward gear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(gear_command_o == '0 || gear_command_o == 3'd7))
    else $error("gear command out of range");

  // Clutch never exceeds the first-gear ceiling of the largest press level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> clutch_out_o <= ClutchMax)
    else $error("clutch level out of range");

endmodule

bind gear_shift_and_clutch_control gscc_checker u_gscc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .gear_command_o (gear_command_o),
  .clutch_out_o   (clutch_out_o)
);

### sim/gscc_shift_checker.sv
`timescale 1ns / 1ps
// Checker for the gear shift and clutch control block: watches the input, result and
// register channels, predicts each result and counts mismatches. Depends on gscc_pkg.
module gscc_shift_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [3:0]                   gear_now_i,
  input  logic        [gscc_pkg::RpmW-1:0]    engine_rpm_i,
  input  logic        [gscc_pkg::DistW-1:0]   distance_raced_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic        [gscc_pkg::GearW-1:0]   gear_command_i,
  input  logic        [gscc_pkg::ClutchW-1:0] clutch_out_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic        [gscc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic        [gscc_pkg::CfgDatW-1:0] cfg_data_i,
  output int                                  fail_count_o,
  output int                                  outstanding_o,
  output int                                  results_o,
  output int                                  upshifts_o,
  output int                                  downshifts_o
);
  import gscc_pkg::*;

  localparam int FirstCeilNum = 13;
  localparam int FirstCeilDen = 10;
  localparam int ReportLimit  = 10;

  typedef struct packed {
    logic [GearW-1:0]   gear;
    logic [ClutchW-1:0] clutch;
  } tick_result_t;

  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_UP,
    SHIFT_DOWN
  } shift_e;

  // Shadow registers and drive state
  logic [RpmW-1:0]    up_rpm;
  logic [RpmW-1:0]    down_rpm [2:6];
  logic [PressW-1:0]  press;
  logic [DistW-1:0]   launch;
  logic [HoldW-1:0]   holdoff;
  logic [ClutchW-1:0] clutch_lvl;

  tick_result_t expected_ticks [$];
  int fails = 0;
  int results = 0;
  int ups = 0;
  int downs = 0;

  // Advance holdoff and clutch by one tick and work out the commanded gear
  function automatic shift_e step_tick(input int gear_in, input int rpm, input int meters,
                                       inout int hold, inout int lvl, output int cmd);
    int gear;
    int ceil_lvl;
    int step;
    int p;
    shift_e kind;
    kind = SHIFT_NONE;
    p = int'(press);
    // gear seven behaves as top gear
    gear = (gear_in > int'(GearTop)) ? int'(GearTop) : gear_in;
    if (hold > 0) hold--;
    if (gear < int'(GearFirst)) begin
      cmd = int'(GearFirst);
    end else if (gear < int'(GearTop) && rpm > int'(up_rpm) && hold == 0) begin
      hold = int'(HoldUp);
      lvl  = p;
      cmd  = gear + 1;
      kind = SHIFT_UP;
    end else if (gear > int'(GearFirst) && rpm < int'(down_rpm[gear]) && hold == 0) begin
      hold = int'(HoldDown);
      lvl  = p;
      cmd  = gear - 1;
      kind = SHIFT_DOWN;
    end else begin
      cmd = gear;
    end
    // hold the clutch pressed at launch
    if (meters < int'(launch)) lvl = p;
    // decay towards zero; first gear and below get a higher ceiling, half the step
    if (lvl > 0) begin
      ceil_lvl = p;
      step     = int'(StepFast);
      if (gear < 2) begin
        step     = int'(StepFirst);
        ceil_lvl = p * FirstCeilNum / FirstCeilDen;
      end
      if (lvl > ceil_lvl) lvl = ceil_lvl;
      if (lvl != ceil_lvl) begin
        lvl = (lvl > step) ? lvl - step : 0;
      end else begin
        lvl = (lvl > int'(StepSlow)) ? lvl - int'(StepSlow) : 0;
      end
    end
    return kind;
  endfunction

  task automatic note_fail(input string msg);
    fails++;
    if (fails <= ReportLimit) $display("%s", msg);
  endtask

  // Track registers, predict accepted ticks and compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin : track
    int hold_n;
    int lvl_n;
    int cmd;
    shift_e kind;
    tick_result_t got;
    tick_result_t want;
    if (!rst_ni) begin
      up_rpm      = UpRpmRst;
      down_rpm[2] = DownRpm2Rst;
      down_rpm[3] = DownRpm3Rst;
      down_rpm[4] = DownRpm4Rst;
      down_rpm[5] = DownRpm5Rst;
      down_rpm[6] = DownRpm6Rst;
      press       = PressRst;
      launch      = LaunchRst;
      holdoff     = '0;
      clutch_lvl  = '0;
      expected_ticks.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{gear: gear_command_i, clutch: clutch_out_i};
        results++;
        if (expected_ticks.size() == 0) begin
          note_fail($sformatf("result %0d unexpected: gear %0d clutch %0d",
                              results, got.gear, got.clutch));
        end else begin
          want = expected_ticks.pop_front();
          if (got.gear !== want.gear || got.clutch !== want.clutch) begin
            note_fail($sformatf("result %0d: gear %0d (want %0d), clutch %0d (want %0d)",
                                results, got.gear, want.gear, got.clutch, want.clutch));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_UPSHIFT_RPM: up_rpm      = cfg_data_i[RpmW-1:0];
          CFG_DOWN_RPM_G2: down_rpm[2] = cfg_data_i[RpmW-1:0];
          CFG_DOWN_RPM_G3: down_rpm[3] = cfg_data_i[RpmW-1:0];
          CFG_DOWN_RPM_G4: down_rpm[4] = cfg_data_i[RpmW-1:0];
          CFG_DOWN_RPM_G5: down_rpm[5] = cfg_data_i[RpmW-1:0];
          CFG_DOWN_RPM_G6: down_rpm[6] = cfg_data_i[RpmW-1:0];
          CFG_PRESS_LEVEL: press       = cfg_data_i[PressW-1:0];
          CFG_LAUNCH_DIST: launch      = cfg_data_i[DistW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        hold_n = int'(holdoff);
        lvl_n  = int'(clutch_lvl);
        kind = step_tick(int'(gear_now_i), int'(engine_rpm_i), int'(distance_raced_i),
                         hold_n, lvl_n, cmd);
        holdoff    = hold_n[HoldW-1:0];
        clutch_lvl = lvl_n[ClutchW-1:0];
        expected_ticks.push_back('{gear: cmd[GearW-1:0], clutch: clutch_lvl});
        if (kind == SHIFT_UP) ups++;
        if (kind == SHIFT_DOWN) downs++;
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= expected_ticks.size();
    results_o     <= results;
    upshifts_o    <= ups;
    downshifts_o  <= downs;
  end

endmodule

### sim/gear_shift_and_clutch_control_tb.sv
`timescale 1ns / 1ps
// Testbench top for the gear shift and clutch control block: drives ticks and register
// settings, stalls the result side, and gives the verdict. Depends on gscc_pkg, the block
// and gscc_shift_checker.
module gear_shift_and_clutch_control_tb;
  import gscc_pkg::*;

  localparam int ClkPeriod   = 8;
  localparam int ResetCycles = 10;
  localparam int TimeoutNs   = 2_000_000;
  localparam int LongHold    = 48;
  localparam int HoldEvery   = 150;
  localparam int LongHolds   = 3;
  localparam int PhaseTicks  = 100;
  localparam int DrainCycles = 4;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = CfgIdxW'(CFG_LAUNCH_DIST + 1);

  typedef enum int {
    SET_FLOOR,
    SET_CEILING,
    SET_RANDOM,
    SET_LIGHT_CLUTCH,
    SET_RAW,
    SET_DEFAULT
  } setting_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [3:0]   gear_now = '0;
  logic [RpmW-1:0]     engine_rpm = '0;
  logic [DistW-1:0]    distance_raced = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [GearW-1:0]    gear_command;
  logic [ClutchW-1:0]  clutch_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDatW-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;
  int results;
  int upshifts;
  int downshifts;

  // Stimulus shaping state
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_sent = 0;
  int settings_done = 0;
  int long_holds = 0;
  int hold_left = 0;
  int road_gear = 1;
  int up_thr = UpRpmRst;
  int down_thr [2:6] = '{DownRpm2Rst, DownRpm3Rst, DownRpm4Rst, DownRpm5Rst, DownRpm6Rst};
  int launch_thr = LaunchRst;

  gear_shift_and_clutch_control dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .gear_now_i       (gear_now),
    .engine_rpm_i     (engine_rpm),
    .distance_raced_i (distance_raced),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .gear_command_o   (gear_command),
    .clutch_out_o     (clutch_out),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  gscc_shift_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .gear_now_i       (gear_now),
    .engine_rpm_i     (engine_rpm),
    .distance_raced_i (distance_raced),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .gear_command_i   (gear_command),
    .clutch_out_i     (clutch_out),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding),
    .results_o        (results),
    .upshifts_o       (upshifts),
    .downshifts_o     (downshifts)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Stall the result side: random stalls, plus a few long holds to back up the input
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_holds < LongHolds && results >= (long_holds + 1) * HoldEvery) begin
      long_holds++;
      hold_left = LongHold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one tick, with random gaps before it, and wait until it is taken
  task automatic send_tick(input int gear, input int rpm, input int meters);
    if (n_sent < 200) begin
      send_idle_pct = 32;
      recv_idle_pct = 69;
    end else if (n_sent < 400) begin
      send_idle_pct = 69;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    gear_now       <= gear[3:0];
    engine_rpm     <= rpm[RpmW-1:0];
    distance_raced <= meters[DistW-1:0];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_sent++;
  endtask

  // Drop valid and wait until every expected result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // Write a whole register setting, plus one write to an unused index
  task automatic load_setting(input setting_e kind);
    logic [CfgDatW-1:0] val [8];
    for (int i = CFG_UPSHIFT_RPM; i <= CFG_LAUNCH_DIST; i++) begin
      case (kind)
        SET_FLOOR:   val[i] = '0;
        SET_CEILING: val[i] = '1;
        SET_RANDOM:  val[i] = CfgDatW'($urandom_range(20000));
        SET_LIGHT_CLUTCH: val[i] = CfgDatW'($urandom_range(12000, 2000));
        SET_RAW:     val[i] = CfgDatW'($urandom_range(16'hFFFF));
        default:     val[i] = '0;
      endcase
    end
    case (kind)
      SET_RANDOM: begin
        val[CFG_PRESS_LEVEL] = CfgDatW'($urandom_range(1000));
        val[CFG_LAUNCH_DIST] = CfgDatW'($urandom_range(2000));
      end
      SET_LIGHT_CLUTCH: begin
        // ceilings around the slow step
        val[CFG_PRESS_LEVEL] = CfgDatW'($urandom_range(45, 1));
        val[CFG_LAUNCH_DIST] = CfgDatW'($urandom_range(30));
      end
      SET_DEFAULT: begin
        val[CFG_UPSHIFT_RPM] = CfgDatW'(UpRpmRst);
        val[CFG_DOWN_RPM_G2] = CfgDatW'(DownRpm2Rst);
        val[CFG_DOWN_RPM_G3] = CfgDatW'(DownRpm3Rst);
        val[CFG_DOWN_RPM_G4] = CfgDatW'(DownRpm4Rst);
        val[CFG_DOWN_RPM_G5] = CfgDatW'(DownRpm5Rst);
        val[CFG_DOWN_RPM_G6] = CfgDatW'(DownRpm6Rst);
        val[CFG_PRESS_LEVEL] = CfgDatW'(PressRst);
        val[CFG_LAUNCH_DIST] = LaunchRst;
      end
      default: ;
    endcase
    for (int i = CFG_UPSHIFT_RPM; i <= CFG_LAUNCH_DIST; i++) begin
      write_reg(CfgIdxW'(i), val[i]);
    end
    write_reg(CfgIdxW'($urandom_range(int'(CfgIdxSpareLo) + 7, int'(CfgIdxSpareLo))),
              CfgDatW'($urandom_range(16'hFFFF)));
    cfg_valid <= 1'b0;
    settings_done++;
    // keep a note of the thresholds to aim the stimulus at
    up_thr = int'(val[CFG_UPSHIFT_RPM][RpmW-1:0]);
    for (int g = 2; g <= 6; g++) down_thr[g] = int'(val[CFG_DOWN_RPM_G2 + g - 2][RpmW-1:0]);
    launch_thr = int'(val[CFG_LAUNCH_DIST]);
  endtask

  // Mostly drive-like ticks around the thresholds, the rest raw noise
  task automatic drive_random_ticks(input int count);
    int gear;
    int rpm;
    int meters;
    int anchor;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 20) begin
        gear   = $urandom_range(15) - 8;
        rpm    = $urandom_range(32767);
        meters = $urandom_range(65535);
      end else begin
        gear = road_gear;
        if (gear == int'(GearFirst) || $urandom_range(1) == 1) anchor = up_thr;
        else anchor = down_thr[gear];
        rpm = anchor + int'($urandom_range(600)) - 300;
        if (rpm < 0) rpm = 0;
        if (rpm > 32767) rpm = 32767;
        if ($urandom_range(99) < 10) meters = $urandom_range(launch_thr);
        else meters = $urandom_range(65535, launch_thr);
        // follow the schedule now and then, as a driver would
        if (rpm > up_thr && road_gear < int'(GearTop) && $urandom_range(99) < 30) begin
          road_gear++;
        end else if (road_gear > int'(GearFirst) && rpm < down_thr[road_gear]
                     && $urandom_range(99) < 30) begin
          road_gear--;
        end
      end
      send_tick(gear, rpm, meters);
    end
  endtask

  initial begin : stimulus
    int rpm;
    int meters;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: upshift, then every gear code and field extreme while the holdoff
    // blocks shifts, then the downshift once the holdoff has run out
    send_tick(3, UpRpmRst + 1, 100);
    for (int k = 0; k < 19; k++) begin
      case (k % 4)
        0:       begin rpm = 0;            meters = 65535;         end
        1:       begin rpm = 32767;        meters = 0;             end
        2:       begin rpm = UpRpmRst;     meters = LaunchRst - 1; end
        default: begin rpm = UpRpmRst + 1; meters = LaunchRst;     end
      endcase
      send_tick((k % 16) - 8, rpm, meters);
    end
    send_tick(6, 0, 65535);
    send_tick(5, 32767, 65535);
    send_tick(2, 0, 0);

    // Random ticks under each register setting
    for (int ph = SET_FLOOR; ph <= SET_DEFAULT; ph++) begin
      wait_drained();
      load_setting(setting_e'(ph));
      drive_random_ticks(PhaseTicks);
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Drove %0d ticks under reset defaults and %0d register settings, extremes included.",
             n_sent, settings_done);
    $display("Checked %0d results; %0d upshifts and %0d downshifts predicted.",
             results, upshifts, downshifts);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Give up on a run that hangs
  initial begin : watchdog
    #(TimeoutNs);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
